@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Minterm bitstream decoder package
// Constants, codes and the request/result types shared by the decoder.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int unsigned MAX_VARS       = 1024;
  localparam int unsigned LANES          = 32;
  localparam int unsigned MAX_TOTAL_BITS = 2 * MAX_VARS + 4;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [1:0] CODE_ZERO = 2'b01;
  localparam logic [1:0] CODE_ONE  = 2'b10;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_MINTERM = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_VAR_CODE    = 1'b0,
    ERR_HEADER_BITS = 1'b1
  } err_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_MINTERM,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_HDR_ERR,
    CMD_MINTERM
  } cmd_op_t;

  // One classified stream word on its way from the front to the back.
  typedef struct packed {
    cmd_op_t     op;
    logic [63:0] data;
    logic [10:0] nvars;
    logic [5:0]  vcount;
    logic        tvalid;
    logic [2:0]  tval;
    logic        fin;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [10:0] num_vars;
    logic [63:0] minterm_total;
    logic [31:0] var_bits;
    logic [5:0]  var_count;
    logic        terminal_valid;
    logic [2:0]  terminal;
    logic        final_minterm;
    err_t        error_code;
  } res_t;

  // Terminal class from its three bits, first bit most significant; first and third both set give zero.
  function automatic logic [2:0] term_value(input logic w1, input logic w2,
                                            input logic w3);
    logic [2:0] v;
    v = (w1 && w3) ? 3'd0 : {w1, w2, w3};
    return v;
  endfunction

endpackage

@@ rtl/core/mbd_ifs.sv @@
// ----------------------------------------------------------------------------
// Minterm bitstream decoder channels
// Valid/ready channels for stream words in and decoded results out.
// ----------------------------------------------------------------------------
interface mbd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface mbd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] num_vars;
  logic [63:0] minterm_total;
  logic [31:0] var_bits;
  logic [5:0]  var_count;
  logic        terminal_valid;
  logic [2:0]  terminal;
  logic        final_minterm;
  logic        error_code;

  modport source (output valid, output kind, output num_vars, output minterm_total,
                  output var_bits, output var_count, output terminal_valid,
                  output terminal, output final_minterm, output error_code,
                  input ready);
  modport sink (input valid, input kind, input num_vars, input minterm_total,
                input var_bits, input var_count, input terminal_valid,
                input terminal, input final_minterm, input error_code,
                output ready);
endinterface

@@ rtl/core/mbd_front.sv @@
// ----------------------------------------------------------------------------
// Minterm bitstream decoder front end
// Tracks header and minterm framing, gathers terminal bits, issues requests.
// ----------------------------------------------------------------------------
module mbd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [63:0]   in_word,
  input  logic          space,
  output logic          push,
  output mbd_pkg::cmd_t cmd
);

  mbd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [10:0] vpm_r, vpm_nxt;
  logic [63:0] left_r, left_nxt;
  logic [10:0] vars_left_r, vars_left_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [1:0]  tcnt_r, tcnt_nxt;

  logic        accept;
  logic        hdr_bad;
  logic [63:0] hdr_minus3;
  logic [5:0]  vc;
  logic [10:0] vl_after;
  logic [6:0]  pos;
  logic [6:0]  avail;
  logic [6:0]  need;
  logic [66:0] word_ext;
  logic [2:0]  win;
  logic        term_done;
  logic        w1, w2, w3;
  logic [63:0] left_dec;
  logic        last;

  assign accept     = in_valid && space;
  assign hdr_minus3 = in_word - 64'd3;
  assign hdr_bad    = (in_word < 64'd3) || (in_word > 64'(mbd_pkg::MAX_TOTAL_BITS));

  // At most 32 codes fit in one word.
  assign vc       = (vars_left_r > 11'(mbd_pkg::LANES)) ? 6'(mbd_pkg::LANES)
                                                        : vars_left_r[5:0];
  assign vl_after = vars_left_r - {5'd0, vc};
  assign pos      = {vc, 1'b0};
  assign avail    = 7'd64 - pos;
  assign need     = 7'd3 - {5'd0, tcnt_r};
  assign word_ext = {3'b000, in_word};
  assign win      = word_ext[pos +: 3];
  assign term_done = (vl_after == 11'd0) && (avail >= need);
  assign left_dec  = left_r - 64'd1;
  assign last      = (left_dec == 64'd0);

  always_comb begin
    case (tcnt_r)
      2'd0: begin
        w1 = win[0];
        w2 = win[1];
        w3 = win[2];
      end
      2'd1: begin
        w1 = held_r[0];
        w2 = win[0];
        w3 = win[1];
      end
      default: begin
        w1 = held_r[0];
        w2 = held_r[1];
        w3 = win[0];
      end
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      mbd_pkg::PH_HEADER: begin
        if (accept && hdr_idx_r == 2'd0 && hdr_bad) begin
          phase_nxt = mbd_pkg::PH_ERROR;
        end else if (accept && hdr_idx_r == 2'd3) begin
          phase_nxt = (left_r == 64'd0) ? mbd_pkg::PH_DONE : mbd_pkg::PH_MINTERM;
        end
      end
      mbd_pkg::PH_MINTERM: begin
        if (accept && term_done && last) begin
          phase_nxt = mbd_pkg::PH_DONE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Requests and framing counters.
  always_comb begin
    hdr_idx_nxt   = hdr_idx_r;
    vpm_nxt       = vpm_r;
    left_nxt      = left_r;
    vars_left_nxt = vars_left_r;
    held_nxt      = held_r;
    tcnt_nxt      = tcnt_r;
    push          = 1'b0;
    cmd           = '0;
    case (phase_r)
      mbd_pkg::PH_HEADER: begin
        if (accept) begin
          case (hdr_idx_r)
            2'd0: begin
              if (hdr_bad) begin
                push   = 1'b1;
                cmd.op = mbd_pkg::CMD_HDR_ERR;
              end else begin
                vpm_nxt     = hdr_minus3[11:1];
                hdr_idx_nxt = 2'd1;
              end
            end
            2'd1: begin
              left_nxt    = in_word;
              hdr_idx_nxt = 2'd2;
            end
            2'd2: hdr_idx_nxt = 2'd3;
            default: begin
              hdr_idx_nxt   = 2'd0;
              push          = 1'b1;
              cmd.op        = mbd_pkg::CMD_HEADER;
              cmd.nvars     = vpm_r;
              cmd.data      = left_r;
              vars_left_nxt = vpm_r;
              held_nxt      = 2'd0;
              tcnt_nxt      = 2'd0;
            end
          endcase
        end
      end
      mbd_pkg::PH_MINTERM: begin
        if (accept) begin
          push       = 1'b1;
          cmd.op     = mbd_pkg::CMD_MINTERM;
          cmd.data   = in_word;
          cmd.vcount = vc;
          cmd.tvalid = term_done;
          cmd.tval   = term_done ? mbd_pkg::term_value(w1, w2, w3) : 3'd0;
          cmd.fin    = term_done && last;
          if (term_done) begin
            left_nxt      = left_dec;
            vars_left_nxt = vpm_r;
            held_nxt      = 2'd0;
            tcnt_nxt      = 2'd0;
          end else begin
            vars_left_nxt = vl_after;
            if (vl_after == 11'd0) begin
              // The terminal runs into the next word; keep what this one has.
              tcnt_nxt = tcnt_r + avail[1:0];
              case (tcnt_r)
                2'd0: begin
                  if (avail >= 7'd1) held_nxt[0] = win[0];
                  if (avail >= 7'd2) held_nxt[1] = win[1];
                end
                2'd1: begin
                  if (avail >= 7'd1) held_nxt[1] = win[0];
                end
                default: held_nxt = held_r;
              endcase
            end
          end
        end
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mbd_pkg::PH_HEADER;
      hdr_idx_r   <= 2'd0;
      vpm_r       <= 11'd0;
      left_r      <= 64'd0;
      vars_left_r <= 11'd0;
      held_r      <= 2'd0;
      tcnt_r      <= 2'd0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      vpm_r       <= vpm_nxt;
      left_r      <= left_nxt;
      vars_left_r <= vars_left_nxt;
      held_r      <= held_nxt;
      tcnt_r      <= tcnt_nxt;
    end
  end

endmodule

@@ rtl/core/mbd_queue.sv @@
// ----------------------------------------------------------------------------
// Minterm bitstream decoder request queue
// Short FIFO that decouples the framing front end from the decode back end.
// ----------------------------------------------------------------------------
module mbd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbd_pkg::cmd_t din,
  output logic          space,
  input  logic          pop,
  output logic          nonempty,
  output mbd_pkg::cmd_t dout
);

  mbd_pkg::cmd_t entry_r [mbd_pkg::QDEPTH];
  logic [mbd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mbd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mbd_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign space    = (count_r != mbd_pkg::QCNT_W'(mbd_pkg::QDEPTH));
  assign nonempty = (count_r != '0);
  assign do_push  = push && space;
  assign do_pop   = pop && nonempty;
  assign dout     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mbd_pkg::QPTR_W'(mbd_pkg::QDEPTH - 1)) ? '0
                                                                      : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mbd_pkg::QPTR_W'(mbd_pkg::QDEPTH - 1)) ? '0
                                                                      : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/core/mbd_back.sv @@
// ----------------------------------------------------------------------------
// Minterm bitstream decoder back end
// Decodes the variable codes of a word, holds the sticky error, drives results.
// ----------------------------------------------------------------------------
module mbd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mbd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output mbd_pkg::res_t out_res
);

  logic          out_valid_r, out_valid_nxt;
  logic          err_r, err_nxt;
  mbd_pkg::res_t res_r, res_nxt;

  logic [mbd_pkg::LANES-1:0] bad_lane;
  logic [mbd_pkg::LANES-1:0] vbits;
  logic                      code_err;
  logic                      is_err;
  logic                      load;

  // All 32 code lanes decode side by side; lanes past vcount are masked.
  always_comb begin
    logic [1:0] code;
    logic       lane_en;
    for (int i = 0; i < mbd_pkg::LANES; i++) begin
      code        = q_cmd.data[2*i +: 2];
      lane_en     = (6'(i) < q_cmd.vcount);
      bad_lane[i] = lane_en && !(code inside {mbd_pkg::CODE_ZERO, mbd_pkg::CODE_ONE});
      vbits[i]    = lane_en && (code == mbd_pkg::CODE_ONE);
    end
  end

  assign code_err = |bad_lane;

  always_comb begin
    res_nxt = '0;
    is_err  = 1'b0;
    case (q_cmd.op)
      mbd_pkg::CMD_HEADER: begin
        res_nxt.kind          = mbd_pkg::KIND_HEADER;
        res_nxt.num_vars      = q_cmd.nvars;
        res_nxt.minterm_total = q_cmd.data;
      end
      mbd_pkg::CMD_HDR_ERR: begin
        res_nxt.kind       = mbd_pkg::KIND_ERROR;
        res_nxt.error_code = mbd_pkg::ERR_HEADER_BITS;
        is_err             = 1'b1;
      end
      mbd_pkg::CMD_MINTERM: begin
        if (code_err) begin
          res_nxt.kind       = mbd_pkg::KIND_ERROR;
          res_nxt.error_code = mbd_pkg::ERR_VAR_CODE;
          is_err             = 1'b1;
        end else begin
          res_nxt.kind           = mbd_pkg::KIND_MINTERM;
          res_nxt.var_bits       = vbits;
          res_nxt.var_count      = q_cmd.vcount;
          res_nxt.terminal_valid = q_cmd.tvalid;
          res_nxt.terminal       = q_cmd.tval;
          res_nxt.final_minterm  = q_cmd.fin;
        end
      end
      default: res_nxt = '0;
    endcase
  end

  // Once an error result has been loaded, every later request is drained and dropped.
  assign q_pop         = q_valid && (!out_valid_r || out_ready);
  assign load          = q_pop && !err_r;
  assign err_nxt       = err_r || (load && is_err);
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

@@ rtl/core/minterm_bitstream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Minterm bitstream decoder
// Decodes a header and minterm records from a stream of 64-bit words.
// ----------------------------------------------------------------------------
// The decoder takes one 64-bit word per clock cycle while the request queue has
// space, with no bubbles between words, whatever the word holds. At most one
// result comes out per word, in order. The accepting edge writes the request
// queue, and a later edge loads the output register once the output is free;
// the result is valid from then on. The front end does all framing
// combinationally as each word is accepted. The two-entry queue and the
// registered output let the input take two more words while a result waits on
// the output; after that the input stalls. There is no clearing pass after
// reset. After any error result, nothing more is reported until reset.
module minterm_bitstream_decoder_top (
  input logic      clk,
  input logic      rst_n,
  mbd_in_if.sink   in_ch,
  mbd_out_if.source out_ch
);

  mbd_pkg::cmd_t front_cmd;
  mbd_pkg::cmd_t back_cmd;
  mbd_pkg::res_t res;
  logic          front_push;
  logic          q_space;
  logic          q_nonempty;
  logic          q_pop;

  mbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_word  (in_ch.word),
    .space    (q_space),
    .push     (front_push),
    .cmd      (front_cmd)
  );

  mbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .din      (front_cmd),
    .space    (q_space),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (back_cmd)
  );

  mbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nonempty),
    .q_cmd     (back_cmd),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign in_ch.ready           = q_space;
  assign out_ch.kind           = res.kind;
  assign out_ch.num_vars       = res.num_vars;
  assign out_ch.minterm_total  = res.minterm_total;
  assign out_ch.var_bits       = res.var_bits;
  assign out_ch.var_count      = res.var_count;
  assign out_ch.terminal_valid = res.terminal_valid;
  assign out_ch.terminal       = res.terminal;
  assign out_ch.final_minterm  = res.final_minterm;
  assign out_ch.error_code     = res.error_code;

endmodule

@@ rtl/core/mbd_checker.sv @@
// ----------------------------------------------------------------------------
// Minterm bitstream decoder port checker
// Watches the result channel of the decoder for ordering and protocol slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [63:0] out_minterm_total,
  input logic [31:0] out_var_bits,
  input logic [5:0]  out_var_count,
  input logic        out_terminal_valid
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_kind) && $stable(out_var_bits) && $stable(out_minterm_total), "result changed while stalled")

  // An error is the last result until reset.
  `ASSERT_NEXT(a_err_last, clk, rst_n, out_valid && out_ready && out_kind == mbd_pkg::KIND_ERROR, !out_valid, "result after an error")

  `ASSERT_NOW(a_res_shape, clk, rst_n, out_valid, out_kind != 2'd3 && out_var_count <= 6'd32 && (!out_terminal_valid || out_kind == mbd_pkg::KIND_MINTERM), "malformed result")

endmodule

bind minterm_bitstream_decoder_top mbd_checker u_mbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_kind           (out_ch.kind),
  .out_minterm_total  (out_ch.minterm_total),
  .out_var_bits       (out_ch.var_bits),
  .out_var_count      (out_ch.var_count),
  .out_terminal_valid (out_ch.terminal_valid)
);
